@@ sv/ird_pkg.sv @@
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types and constants for the integer to radix digit converter.
// ----------------------------------------------------------------------------
package ird_pkg;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int GLYPH_W = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [GLYPH_W-1:0] MINUS_GLYPH = 8'h2D;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [GLYPH_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    case (d)
      4'd0:    g = 8'h30;
      4'd1:    g = 8'h31;
      4'd2:    g = 8'h32;
      4'd3:    g = 8'h33;
      4'd4:    g = 8'h34;
      4'd5:    g = 8'h35;
      4'd6:    g = 8'h36;
      4'd7:    g = 8'h37;
      4'd8:    g = 8'h38;
      4'd9:    g = 8'h39;
      4'd10:   g = 8'h80;
      4'd11:   g = 8'h81;
      4'd12:   g = 8'h82;
      4'd13:   g = 8'h83;
      4'd14:   g = 8'h84;
      4'd15:   g = 8'h85;
      default: g = 8'h30;
    endcase
    return g;
  endfunction

endpackage

@@ sv/ird_ram.sv @@
// ----------------------------------------------------------------------------
// ird_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ird_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ird_divider.sv @@
// ----------------------------------------------------------------------------
// ird_divider
// Restoring divider by a small divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ird_divider #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [VALUE_WIDTH-1:0]         dividend,
  input  logic [ird_pkg::RADIX_W-1:0]    divisor,
  output logic [VALUE_WIDTH-1:0]         quotient,
  output logic [ird_pkg::DIGIT_W-1:0]    remainder,
  output ird_pkg::div_stat_t             stat
);
  import ird_pkg::*;

  localparam int STEP_W = $clog2(VALUE_WIDTH);

  logic                   busy;
  logic                   done;
  logic [STEP_W-1:0]      step;
  logic [VALUE_WIDTH-1:0] quo;
  logic [DIGIT_W-1:0]     rem;
  logic [RADIX_W-1:0]     dvs;

  logic [RADIX_W-1:0]     trial;
  logic                   ge;
  logic [RADIX_W-1:0]     diff;

  assign trial = {rem, quo[VALUE_WIDTH-1]};
  assign ge    = (trial >= dvs);
  assign diff  = trial - dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(VALUE_WIDTH - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[VALUE_WIDTH-2:0], ge};
      rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ sv/integer_to_radix_digits_core.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Signed integer to digit string in base 2..16, most significant digit first.
// ----------------------------------------------------------------------------
// Takes one signed value per input beat and returns its characters as a run
// of output beats, tlast on the final one: '-' first for a negative value,
// then digits '0'-'9' or 0x80-0x85 for ten to fifteen; zero gives "0". The
// radix register (reset 10) clamps to 2..16. The user must see that it is
// written only while idle; the block itself does not enforce this. One
// restoring divider produces each digit, one quotient bit per cycle;
// digits are buffered in a small RAM and read back in reverse, each one
// loaded into the output register and held until the sink takes it. The
// input is not ready until the last character of the previous item is
// taken.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   radix_we,
  input  logic [ird_pkg::RADIX_W-1:0]            radix_wdata,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [ird_pkg::GLYPH_W-1:0]            m_tdata,   // [7:0] glyph
  output logic                                   m_tlast
);
  import ird_pkg::*;

  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int ADDR_W = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FETCH,
    S_LOAD,
    S_SEND
  } state_t;

  state_t                 state;
  logic [RADIX_W-1:0]     radix;
  logic [CNT_W-1:0]       dcount;
  logic                   sign_pend;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] mag;
  logic [RADIX_W-1:0]     eff_radix;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [DIGIT_W-1:0]     div_rem;
  div_stat_t              div_stat;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [CNT_W-1:0]       dcount_dec;
  logic [DIGIT_W-1:0]     ram_rdata;

  assign value     = s_tdata[VALUE_WIDTH-1:0];
  assign mag       = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
  assign eff_radix = (radix < RADIX_MIN) ? RADIX_MIN :
                     (radix > RADIX_MAX) ? RADIX_MAX : radix;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign div_start    = accept ||
                        ((state == S_DIV) && div_stat.done && (div_quo != '0));
  assign div_dividend = accept ? mag : div_quo;

  assign ram_we     = (state == S_DIV) && div_stat.done && (dcount < CNT_W'(VALUE_WIDTH));
  assign ram_waddr  = dcount[ADDR_W-1:0];
  assign dcount_dec = dcount - 1'b1;
  assign ram_raddr  = dcount_dec[ADDR_W-1:0];

  ird_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_radix),
    .quotient (div_quo),
    .remainder(div_rem),
    .stat     (div_stat)
  );

  ird_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_WIDTH)
  ) u_digit_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(div_rem),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dcount    <= '0;
      sign_pend <= 1'b0;
      m_tvalid  <= 1'b0;
      m_tlast   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            dcount    <= '0;
            sign_pend <= value[VALUE_WIDTH-1];
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (ram_we) begin
              dcount <= dcount + 1'b1;
            end
            if (div_quo == '0) begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (sign_pend) begin
            sign_pend <= 1'b0;
            m_tdata   <= MINUS_GLYPH;
            m_tlast   <= 1'b0;
            m_tvalid  <= 1'b1;
            state     <= S_SEND;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          m_tdata  <= digit_glyph(ram_rdata);
          m_tlast  <= (dcount == CNT_W'(1));
          m_tvalid <= 1'b1;
          dcount   <= dcount_dec;
          state    <= S_SEND;
        end
        S_SEND: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= (dcount == '0) ? S_IDLE : S_LOAD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // idle never overlaps a pending output beat
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid)
    else $error("input ready while an output beat is pending");

  assert property (@(posedge clk) disable iff (rst) dcount <= CNT_W'(VALUE_WIDTH))
    else $error("digit count beyond value width");

  assert property (@(posedge clk) disable iff (rst) div_stat.done |-> state == S_DIV)
    else $error("divider finished outside digit loop");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata != MINUS_GLYPH)
    else $error("minus sign flagged as last character");

  assert property (@(posedge clk) disable iff (rst) accept |=> div_stat.busy)
    else $error("divider not started on accepted beat");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_radix_digits_core.
// ----------------------------------------------------------------------------
// Drives signed values into the converter over several radix settings,
// including the clamped ones, under a range of source idle and sink stall
// patterns and one long sink hold-off. A scoreboard predicts the character
// run of every accepted value and checks each output beat, glyph and tlast,
// in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int VALUE_W       = 32;
  localparam int QUIET_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 1200;
  localparam int PHASE_ITEMS   = 40;
  localparam int NUM_PHASES    = 11;

  typedef struct packed {
    logic [ird_pkg::GLYPH_W-1:0] glyph;
    logic                        is_last;
  } glyph_beat_t;

  class glyph_scoreboard;
    int unsigned radix_reg;
    int unsigned failures;
    glyph_beat_t pending_glyphs[$];

    function new();
      radix_reg = ird_pkg::RADIX_RESET;
      failures  = 0;
    endfunction

    function void set_radix(int unsigned r);
      radix_reg = r;
    endfunction

    function logic [ird_pkg::GLYPH_W-1:0] digit_char(logic [3:0] d);
      if (d < 4'd10) begin
        return 8'h30 + {4'h0, d};
      end
      return 8'h80 + {4'h0, d - 4'd10};
    endfunction

    function void note_value(logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] magnitude;
      int unsigned base;
      logic [3:0] digits[$];
      glyph_beat_t beat;
      if (radix_reg < ird_pkg::RADIX_MIN) begin
        base = ird_pkg::RADIX_MIN;
      end else if (radix_reg > ird_pkg::RADIX_MAX) begin
        base = ird_pkg::RADIX_MAX;
      end else begin
        base = radix_reg;
      end
      magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
      do begin
        digits.insert(digits.size(), 4'(magnitude % base));
        magnitude = magnitude / base;
      end while (magnitude != 0);
      if (value[VALUE_W-1]) begin
        beat.glyph   = ird_pkg::MINUS_GLYPH;
        beat.is_last = 1'b0;
        pending_glyphs.insert(pending_glyphs.size(), beat);
      end
      for (int i = digits.size() - 1; i >= 0; i--) begin
        beat.glyph   = digit_char(digits[i]);
        beat.is_last = (i == 0);
        pending_glyphs.insert(pending_glyphs.size(), beat);
      end
    endfunction

    function void check_char(logic [ird_pkg::GLYPH_W-1:0] glyph, logic is_last);
      glyph_beat_t want;
      if (pending_glyphs.size() == 0) begin
        $error("output beat glyph=%h tlast=%b with no value pending", glyph, is_last);
        failures++;
      end else begin
        want = pending_glyphs.pop_front();
        if (glyph !== want.glyph) begin
          $error("glyph mismatch: expected %h, actual %h", want.glyph, glyph);
          failures++;
        end
        if (is_last !== want.is_last) begin
          $error("tlast mismatch: expected %b, actual %b", want.is_last, is_last);
          failures++;
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          radix_we;
  logic [ird_pkg::RADIX_W-1:0]   radix_wdata;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [VALUE_W-1:0]            s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [ird_pkg::GLYPH_W-1:0]   m_tdata;
  logic                          m_tlast;

  glyph_scoreboard sb;
  int unsigned     src_idle_pct = 0;
  int unsigned     sink_stall_pct = 0;
  bit              hold_req = 1'b0;
  int unsigned     quiet_cycles = 0;

  integer_to_radix_digits_core #(
    .VALUE_WIDTH(VALUE_W)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix_wdata (radix_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(posedge clk);
          m_tready <= 1'b0;
        end
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_value(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        sb.check_char(m_tdata, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("integer_to_radix_digits_core test failed");
        $finish;
      end
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
  endtask

  // drop valid and hold until every character has been taken
  task automatic drain_pending();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_glyphs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_radix(input logic [ird_pkg::RADIX_W-1:0] r);
    drain_pending();
    radix_we    <= 1'b1;
    radix_wdata <= r;
    @(posedge clk);
    radix_we <= 1'b0;
    sb.set_radix(r);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned        width;
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0: v = $urandom;
      1: begin
        v = $urandom_range(20);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      2: begin
        case ($urandom_range(4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h0000_0000;
          default: v = 32'h0000_0001;
        endcase
      end
      default: begin
        width = $urandom_range(1, VALUE_W);
        v = $urandom >> (VALUE_W - width);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [ird_pkg::RADIX_W-1:0] phase_radix [NUM_PHASES];
    sb = new();
    phase_radix = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd7, 5'd3, 5'd13, 5'd10,
                    5'($urandom_range(3, 15))};
    rst         <= 1'b1;
    radix_we    <= 1'b0;
    radix_wdata <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset radix: decimal corners
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFF6);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd1000000000);

    write_radix(5'd16);
    send_value(32'h0FED_CBA9);
    send_value(32'h89AB_CDEF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h0000_000F);
    send_value(32'h0000_000A);

    write_radix(5'd2);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h0000_0001);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_radix(phase_radix[p]);
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      if (p == 4) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_value(random_value());
    end

    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("integer_to_radix_digits_core test passed");
    end else begin
      $display("integer_to_radix_digits_core test failed");
    end
    $finish;
  end

endmodule
